### hw/rtl/jsc_pkg.sv
package jsc_pkg;

  localparam logic [1:0] CMD_FEED   = 2'd0;
  localparam logic [1:0] CMD_FINISH = 2'd1;
  localparam logic [1:0] CMD_REINIT = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SYNTAX = 3'd1;
  localparam logic [2:0] ST_DEPTH  = 3'd2;
  localparam logic [2:0] ST_STATE  = 3'd3;
  localparam logic [2:0] ST_TRUNC  = 3'd4;
  localparam logic [2:0] ST_SKIP   = 3'd5;

  localparam int CNT_BYTES    = 0;
  localparam int CNT_OBJECTS  = 1;
  localparam int CNT_ARRAYS   = 2;
  localparam int CNT_STRINGS  = 3;
  localparam int CNT_NUMBERS  = 4;
  localparam int CNT_LITERALS = 5;
  localparam int CNT_COLONS   = 6;
  localparam int CNT_COMMAS   = 7;
  localparam int CNT_KEY0     = 8;
  localparam int NUM_CNT      = 14;
  localparam int NUM_KEYS     = 6;

  localparam logic [3:0] IDX_DEPTH = 4'd8;
  localparam logic [3:0] IDX_CRC   = 4'd15;

  localparam logic [1:0] BARE_NONE = 2'd0;
  localparam logic [1:0] BARE_NUM  = 2'd1;
  localparam logic [1:0] BARE_LIT  = 2'd2;

  localparam logic [3:0] KEY_SAT = 4'd12;
  localparam logic [31:0] CRC_POLY = 32'h82F63B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [95:0] KEY_TXT [NUM_KEYS] = '{
    96'("id"), 96'("title"), 96'({"create", "_time"}), 96'({"update", "_time"}),
    96'("mapping"), 96'("message")
  };
  localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{4'd2, 4'd5, 4'd11, 4'd11, 4'd7, 4'd7};

  typedef struct packed {
    logic push;
    logic pop;
    logic kind;
  } stack_op_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] c);
    logic [31:0] r;
    r = crc ^ {24'd0, c};
    for (int b = 0; b < 8; b++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

  function automatic logic [7:0] key_char_at(input int k, input logic [3:0] i);
    logic [95:0] txt;
    logic [3:0] sh;
    txt = KEY_TXT[k];
    sh = KEY_LEN[k] - 4'd1 - i;
    return txt[{sh, 3'b000} +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09;
  endfunction

endpackage

### hw/rtl/jsc_stack.sv
module jsc_stack import jsc_pkg::*; #(
  parameter int DEPTH_LIMIT = 64,
  parameter int DW = $clog2(DEPTH_LIMIT + 1)
) (
  input  logic          clk,
  input  stack_op_t     op,
  input  logic [DW-1:0] depth,
  input  logic [DW-1:0] depth_next,
  output logic          top,
  output logic          below
);

  localparam int AW = (DEPTH_LIMIT > 1) ? $clog2(DEPTH_LIMIT) : 1;

  logic mem [DEPTH_LIMIT];
  logic top_r;
  logic rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [DW-1:0] wsum;
  logic [DW-1:0] rsum;

  // top of stack in a register, entries below it in memory
  assign we    = op.push && (depth != '0);
  assign wsum  = depth - DW'(1);
  assign rsum  = depth_next - DW'(2);
  assign waddr = wsum[AW-1:0];
  assign raddr = rsum[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= top_r;
    end
    if (we && waddr == raddr) begin
      rdata <= top_r;
    end else begin
      rdata <= mem[raddr];
    end
    if (op.push) begin
      top_r <= op.kind;
    end else if (op.pop) begin
      top_r <= rdata;
    end
  end

  assign top   = top_r;
  assign below = rdata;

endmodule

### hw/rtl/json_structure_scanner_crc_unit.sv
// result words are registered; a good finish answers with statistics words, not a plain result
// throughput: one byte per cycle while the output is not stalled; a good finish holds off input
// until all sixteen statistics words have been sent
// nesting stack is a one-bit memory with a registered read and a forwarded write
// rst (synchronous) and the reinitialise command clear all scan state and counters
module json_structure_scanner_crc_unit import jsc_pkg::*; #(
  parameter int DEPTH_LIMIT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // data_byte[7:0], chunk_start[8], zero pad
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status[2:0], stat_index[6:3], stat_value[38:7], zero pad
  output logic        m_tuser,   // has_stat
  output logic        m_tlast
);

  localparam int DW = $clog2(DEPTH_LIMIT + 1);

  logic [DW-1:0] depth, depth_next, deepest, deepest_next;
  logic [31:0]   crc, crc_next;
  logic [31:0]   cnt [NUM_CNT];
  logic [NUM_CNT-1:0] inc;
  logic instr, instr_next, esc, esc_next, expkey, expkey_next;
  logic rootseen, rootseen_next, rootclosed, rootclosed_next, skip, skip_next;
  logic [2:0] hex_left, hex_left_next;
  logic [1:0] bare, bare_next;
  logic [5:0] kmatch, kmatch_next;
  logic [3:0] klen, klen_next;
  stack_op_t  op;
  logic top, below;

  logic s_acc, out_free, clear, fin_good;
  logic [1:0] cmd;
  logic [7:0] c;
  logic start;
  logic [2:0] res_st;

  logic out_valid, out_has, out_last;
  logic [2:0] out_st;
  logic [3:0] out_idx;
  logic [31:0] out_val;
  logic emit, emit_next;
  logic [3:0] emit_idx;
  logic [31:0] emit_val;

  assign cmd   = s_tuser;
  assign c     = s_tdata[7:0];
  assign start = s_tdata[8];
  assign out_free = !out_valid || m_tready;
  assign s_tready = !emit && out_free;
  assign s_acc = s_tvalid && s_tready;
  assign clear = rst || (s_acc && cmd == CMD_REINIT);
  assign fin_good = !(instr || esc || hex_left != '0 || depth != '0 || !rootseen || !rootclosed);

  jsc_stack #(.DEPTH_LIMIT(DEPTH_LIMIT), .DW(DW)) u_stack (
    .clk(clk), .op(op), .depth(depth), .depth_next(depth_next), .top(top), .below(below)
  );

  always_comb begin
    logic done, cont, found;
    depth_next = depth; deepest_next = deepest; crc_next = crc; inc = '0;
    instr_next = instr; esc_next = esc; expkey_next = expkey; rootseen_next = rootseen;
    rootclosed_next = rootclosed; skip_next = skip; hex_left_next = hex_left;
    bare_next = bare; kmatch_next = kmatch; klen_next = klen;
    op = '0; res_st = ST_OK; done = 1'b0; cont = 1'b0; found = 1'b0;
    if (s_acc && cmd == CMD_FEED) begin
      if (start) begin
        skip_next = 1'b0;
      end
      if (start && rootclosed) begin
        res_st = ST_STATE;
        skip_next = 1'b1;
      end else if (!start && skip) begin
        res_st = ST_SKIP;
      end else begin
        inc[CNT_BYTES] = 1'b1;
        crc_next = crc_byte(crc, c);
        if (instr) begin
          if (hex_left != '0) begin
            if (!is_hex(c)) res_st = ST_SYNTAX;
            else hex_left_next = hex_left - 3'd1;
          end else if (esc) begin
            esc_next = 1'b0;
            if (c == 8'h75) hex_left_next = 3'd4;
            else if (!(c == 8'h22 || c == 8'h5C || c == 8'h2F || c == 8'h62 ||
                       c == 8'h66 || c == 8'h6E || c == 8'h72 || c == 8'h74))
              res_st = ST_SYNTAX;
          end else if (c == 8'h5C) begin
            esc_next = 1'b1;
          end else if (c == 8'h22) begin
            instr_next = 1'b0;
            inc[CNT_STRINGS] = 1'b1;
            if (expkey) begin
              for (int k = 0; k < NUM_KEYS; k++) begin
                if (!found && kmatch[k] && klen == KEY_LEN[k]) begin
                  inc[CNT_KEY0 + k] = 1'b1;
                  found = 1'b1;
                end
              end
            end
          end else if (c < 8'h20) begin
            res_st = ST_SYNTAX;
          end else begin
            for (int k = 0; k < NUM_KEYS; k++) begin
              if (kmatch[k] && (klen >= KEY_LEN[k] || key_char_at(k, klen) != c))
                kmatch_next[k] = 1'b0;
            end
            if (klen < KEY_SAT) klen_next = klen + 4'd1;
          end
        end else begin
          if (bare != BARE_NONE) begin
            if (bare == BARE_NUM)
              cont = is_digit(c) || c == 8'h2E || c == 8'h65 || c == 8'h45 ||
                     c == 8'h2B || c == 8'h2D;
            else
              cont = c >= 8'h61 && c <= 8'h7A;
            if (cont) begin
              done = 1'b1;
            end else begin
              if (bare == BARE_NUM) inc[CNT_NUMBERS] = 1'b1;
              else inc[CNT_LITERALS] = 1'b1;
              bare_next = BARE_NONE;
            end
          end
          if (!done) begin
            if (is_ws(c)) begin
              res_st = ST_OK;
            end else if (rootclosed) begin
              res_st = ST_SYNTAX;
            end else if (c == 8'h7B || c == 8'h5B) begin
              rootseen_next = 1'b1;
              if (c == 8'h7B) inc[CNT_OBJECTS] = 1'b1;
              else inc[CNT_ARRAYS] = 1'b1;
              if (depth >= DW'(DEPTH_LIMIT)) begin
                res_st = ST_DEPTH;
              end else begin
                op.push = 1'b1;
                op.kind = (c == 8'h7B);
                depth_next = depth + DW'(1);
                if (depth_next > deepest) deepest_next = depth_next;
                expkey_next = (c == 8'h7B);
              end
            end else if (c == 8'h7D || c == 8'h5D) begin
              if (depth == '0 || top != (c == 8'h7D)) begin
                res_st = ST_SYNTAX;
              end else begin
                op.pop = 1'b1;
                depth_next = depth - DW'(1);
                expkey_next = (depth_next != '0) && below;
                if (depth_next == '0) rootclosed_next = 1'b1;
              end
            end else if (c == 8'h22) begin
              instr_next = 1'b1;
              kmatch_next = 6'h3F;
              klen_next = 4'd0;
            end else if (c == 8'h3A) begin
              inc[CNT_COLONS] = 1'b1;
              expkey_next = 1'b0;
            end else if (c == 8'h2C) begin
              inc[CNT_COMMAS] = 1'b1;
              expkey_next = (depth != '0) && top;
            end else if (c == 8'h2D || is_digit(c)) begin
              bare_next = BARE_NUM;
            end else if (c == 8'h74 || c == 8'h66 || c == 8'h6E) begin
              bare_next = BARE_LIT;
            end else begin
              res_st = ST_SYNTAX;
            end
          end
        end
        skip_next = (res_st != ST_OK);
      end
    end else if (s_acc && cmd == CMD_FINISH) begin
      if (!fin_good) begin
        res_st = ST_TRUNC;
      end else begin
        if (bare == BARE_NUM) inc[CNT_NUMBERS] = 1'b1;
        else if (bare == BARE_LIT) inc[CNT_LITERALS] = 1'b1;
        bare_next = BARE_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      depth <= '0; deepest <= '0; crc <= CRC_INIT;
      instr <= 1'b0; esc <= 1'b0; expkey <= 1'b0; rootseen <= 1'b0;
      rootclosed <= 1'b0; skip <= 1'b0; hex_left <= '0; bare <= BARE_NONE;
      kmatch <= 6'h3F; klen <= '0;
      for (int i = 0; i < NUM_CNT; i++) cnt[i] <= '0;
    end else begin
      depth <= depth_next; deepest <= deepest_next; crc <= crc_next;
      instr <= instr_next; esc <= esc_next; expkey <= expkey_next;
      rootseen <= rootseen_next; rootclosed <= rootclosed_next; skip <= skip_next;
      hex_left <= hex_left_next; bare <= bare_next; kmatch <= kmatch_next;
      klen <= klen_next;
      for (int i = 0; i < NUM_CNT; i++) cnt[i] <= cnt[i] + {31'd0, inc[i]};
    end
  end

  // statistics word select
  always_comb begin
    if (emit_idx == IDX_CRC) emit_val = ~crc;
    else if (emit_idx == IDX_DEPTH) emit_val = 32'(deepest);
    else if (emit_idx < IDX_DEPTH) emit_val = cnt[emit_idx];
    else emit_val = cnt[emit_idx - 4'd1];
  end

  assign emit_next = emit && !(out_free && emit_idx == IDX_CRC);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      emit <= 1'b0;
      emit_idx <= '0;
    end else if (out_free) begin
      if (emit) begin
        out_valid <= 1'b1;
        out_st <= ST_OK; out_has <= 1'b1; out_idx <= emit_idx; out_val <= emit_val;
        out_last <= (emit_idx == IDX_CRC);
        emit_idx <= emit_idx + 4'd1;
        emit <= emit_next;
      end else if (s_acc) begin
        out_st <= res_st; out_has <= 1'b0; out_idx <= '0; out_val <= '0; out_last <= 1'b1;
        if (cmd == CMD_FINISH && fin_good) begin
          out_valid <= 1'b0;
          emit <= 1'b1;
          emit_idx <= '0;
        end else begin
          out_valid <= 1'b1;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_val, out_idx, out_st};
  assign m_tuser  = out_has;
  assign m_tlast  = out_last;

endmodule

### hw/rtl/jsc_checker.sv
module jsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word dropped while stalled");

  a_stat_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[2:0] == 3'd0)
    else $error("statistics word with nonzero status");

  a_plain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[38:3] == 36'd0 && m_tlast)
    else $error("plain result carries statistic or misses last");

  a_crc_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast == (m_tdata[6:3] == 4'd15))
    else $error("last does not mark the crc word");

endmodule

bind json_structure_scanner_crc_unit jsc_checker u_jsc_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

### test/json_structure_scanner_crc_checker.sv
`timescale 1ns / 100ps

module json_structure_scanner_crc_checker import jsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [2:0]  status;
    logic        has_stat;
    logic [3:0]  stat_index;
    logic [31:0] stat_value;
    logic        last;
  } scan_word_t;

  localparam int STACK_DEPTH = 64;

  scan_word_t  expected_words[$];
  string       key_names[NUM_KEYS] = '{"id", "title", string'({"create", "_time"}),
                                       string'({"update", "_time"}), "mapping", "message"};
  bit          nest_kind[STACK_DEPTH];
  int          nest_level;
  int          deepest;
  logic [31:0] crc;
  logic [31:0] counts[NUM_CNT];
  bit          in_str, in_esc, want_key, seen_root, closed_root, skipping;
  int          hex_due;
  logic [1:0]  bare;
  logic [5:0]  key_live;
  int          key_len_seen;

  function automatic bit digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit hex_digit(input logic [7:0] c);
    return digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09;
  endfunction

  function automatic logic [31:0] crc32c_step(input logic [31:0] r, input logic [7:0] c);
    logic [31:0] v;
    v = r ^ {24'd0, c};
    for (int b = 0; b < 8; b++) v = (v >> 1) ^ (v[0] ? 32'h82F63B78 : 32'd0);
    return v;
  endfunction

  task automatic clear_scan();
    nest_level = 0;
    deepest = 0;
    crc = 32'hFFFFFFFF;
    for (int i = 0; i < NUM_CNT; i++) counts[i] = 32'd0;
    in_str = 0; in_esc = 0; want_key = 0; seen_root = 0; closed_root = 0; skipping = 0;
    hex_due = 0;
    bare = BARE_NONE;
    key_live = 6'h3F;
    key_len_seen = 0;
  endtask

  task automatic add_word(input logic [2:0] st, input logic h, input logic [3:0] idx,
                          input logic [31:0] val, input logic l);
    scan_word_t w;
    w.status = st; w.has_stat = h; w.stat_index = idx; w.stat_value = val; w.last = l;
    expected_words.push_back(w);
  endtask

  function automatic bit top_object();
    return nest_level > 0 && nest_kind[nest_level - 1];
  endfunction

  task automatic open_nest(input bit obj, inout logic [2:0] st);
    if (nest_level >= STACK_DEPTH) begin
      st = ST_DEPTH;
    end else begin
      nest_kind[nest_level] = obj;
      nest_level++;
      if (nest_level > deepest) deepest = nest_level;
      want_key = obj;
    end
  endtask

  task automatic close_nest(input bit obj, inout logic [2:0] st);
    if (nest_level == 0 || nest_kind[nest_level - 1] != obj) begin
      st = ST_SYNTAX;
    end else begin
      nest_level--;
      want_key = top_object();
      if (nest_level == 0) closed_root = 1;
    end
  endtask

  task automatic key_step(input logic [7:0] c);
    for (int k = 0; k < NUM_KEYS; k++)
      if (key_live[k] && (key_len_seen >= key_names[k].len() ||
                          key_names[k][key_len_seen] != c))
        key_live[k] = 1'b0;
    if (key_len_seen < 12) key_len_seen++;
  endtask

  task automatic key_done();
    bit hit;
    hit = 0;
    if (want_key)
      for (int k = 0; k < NUM_KEYS; k++)
        if (!hit && key_live[k] && key_len_seen == key_names[k].len()) begin
          counts[CNT_KEY0 + k]++;
          hit = 1;
        end
  endtask

  task automatic scan_byte(input logic [7:0] c, output logic [2:0] st);
    bit handled, cont;
    st = ST_OK;
    handled = 0;
    counts[CNT_BYTES]++;
    crc = crc32c_step(crc, c);
    if (in_str) begin
      if (hex_due != 0) begin
        if (!hex_digit(c)) st = ST_SYNTAX;
        else hex_due--;
      end else if (in_esc) begin
        in_esc = 0;
        if (c == "u") hex_due = 4;
        else if (!(c == 8'h22 || c == 8'h5C || c == "/" || c == "b" || c == "f" ||
                   c == "n" || c == "r" || c == "t"))
          st = ST_SYNTAX;
      end else if (c == 8'h5C) begin
        in_esc = 1;
      end else if (c == 8'h22) begin
        in_str = 0;
        counts[CNT_STRINGS]++;
        key_done();
      end else if (c < 8'h20) begin
        st = ST_SYNTAX;
      end else begin
        key_step(c);
      end
    end else begin
      if (bare != BARE_NONE) begin
        if (bare == BARE_NUM)
          cont = digit(c) || c == "." || c == "e" || c == "E" || c == "+" || c == "-";
        else
          cont = c >= "a" && c <= "z";
        if (cont) begin
          handled = 1;
        end else begin
          if (bare == BARE_NUM) counts[CNT_NUMBERS]++;
          else counts[CNT_LITERALS]++;
          bare = BARE_NONE;
        end
      end
      if (!handled) begin
        if (space(c)) begin
        end else if (closed_root) begin
          st = ST_SYNTAX;
        end else if (c == "{") begin
          seen_root = 1; counts[CNT_OBJECTS]++; open_nest(1, st);
        end else if (c == "[") begin
          seen_root = 1; counts[CNT_ARRAYS]++; open_nest(0, st);
        end else if (c == "}") begin
          close_nest(1, st);
        end else if (c == "]") begin
          close_nest(0, st);
        end else if (c == 8'h22) begin
          in_str = 1; key_live = 6'h3F; key_len_seen = 0;
        end else if (c == ":") begin
          counts[CNT_COLONS]++; want_key = 0;
        end else if (c == ",") begin
          counts[CNT_COMMAS]++; want_key = top_object();
        end else if (c == "-" || digit(c)) begin
          bare = BARE_NUM;
        end else if (c == "t" || c == "f" || c == "n") begin
          bare = BARE_LIT;
        end else begin
          st = ST_SYNTAX;
        end
      end
    end
  endtask

  task automatic predict_word(input logic [1:0] cmd, input logic [7:0] c, input logic cs);
    logic [2:0] st;
    case (cmd)
      CMD_FEED: begin
        if (cs) skipping = 0;
        if (cs && closed_root) begin
          skipping = 1;
          add_word(ST_STATE, 0, 0, 0, 1);
        end else if (skipping) begin
          add_word(ST_SKIP, 0, 0, 0, 1);
        end else begin
          scan_byte(c, st);
          if (st != ST_OK) skipping = 1;
          add_word(st, 0, 0, 0, 1);
        end
      end
      CMD_FINISH: begin
        if (in_str || in_esc || hex_due != 0 || nest_level != 0 || !seen_root || !closed_root)
        begin
          add_word(ST_TRUNC, 0, 0, 0, 1);
        end else begin
          if (bare == BARE_NUM) counts[CNT_NUMBERS]++;
          else if (bare == BARE_LIT) counts[CNT_LITERALS]++;
          bare = BARE_NONE;
          for (int k = 0; k < 8; k++) add_word(ST_OK, 1, 4'(k), counts[k], 0);
          add_word(ST_OK, 1, IDX_DEPTH, 32'(deepest), 0);
          for (int k = 0; k < NUM_KEYS; k++)
            add_word(ST_OK, 1, 4'(9 + k), counts[CNT_KEY0 + k], 0);
          add_word(ST_OK, 1, IDX_CRC, ~crc, 1);
        end
      end
      CMD_REINIT: begin
        clear_scan();
        add_word(ST_OK, 0, 0, 0, 1);
      end
      default: add_word(ST_OK, 0, 0, 0, 1);
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    scan_word_t w;
    if (rst) begin
      clear_scan();
      expected_words.delete();
      fails = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected: %0h", m_tdata);
          fails++;
        end else begin
          w = expected_words.pop_front();
          check_field("status", w.status, m_tdata[2:0]);
          check_field("has_stat", w.has_stat, m_tuser);
          check_field("stat_index", w.stat_index, m_tdata[6:3]);
          check_field("stat_value", w.stat_value, m_tdata[38:7]);
          check_field("last", w.last, m_tlast);
        end
      end
      if (s_tvalid && s_tready) predict_word(s_tuser, s_tdata[7:0], s_tdata[8]);
    end
    pending = expected_words.size();
  end

endmodule

### test/tb_json_structure_scanner_crc_unit.sv
`timescale 1ns / 100ps

module tb_json_structure_scanner_crc_unit import jsc_pkg::*;;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = CMD_FEED;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  int          fails;
  int          pending;
  int          cycles = 0;
  int          sent = 0;
  int          burst_left = 0;
  bit          gappy = 1;
  logic [7:0]  doc[$];

  json_structure_scanner_crc_unit dut (.*);
  json_structure_scanner_crc_checker checker_i (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_json_structure_scanner_crc_unit failed");
      $finish;
    end
  end

  // receiver stall pattern: duty cycle over a period, changed now and then
  int stall_period = 4, stall_duty = 4, stall_phase = 0, stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_period = $urandom_range(1, 7);
      stall_duty = ($urandom_range(0, 3) == 0) ? stall_period : $urandom_range(1, stall_period);
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    stall_phase = (stall_phase + 1) % stall_period;
    m_tready <= stall_phase < stall_duty;
  end

  task automatic send_word(input logic [1:0] cmd, input logic [7:0] b, input logic cs);
    if (burst_left == 0) begin
      if (gappy) begin
        s_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= {7'd0, cs, b};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic feed_text(input string s, input bit cs);
    for (int i = 0; i < s.len(); i++) send_word(CMD_FEED, s[i], cs && i == 0);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) doc.push_back(s[i]);
  endtask

  task automatic add_ws();
    logic [7:0] ws[4] = '{8'h20, 8'h0A, 8'h0D, 8'h09};
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      doc.push_back(ws[$urandom_range(0, 3)]);
  endtask

  task automatic add_string(input bit is_key);
    string names[6] = '{"id", "title", string'({"create", "_time"}),
                        string'({"update", "_time"}), "mapping", "message"};
    string escs = "\"\\/bfnrt";
    string hexs = "0123456789abcdefABCDEF";
    string nm;
    doc.push_back(8'h22);
    if (is_key && $urandom_range(0, 9) < 7) begin
      nm = names[$urandom_range(0, 5)];
      for (int i = 0; i < nm.len(); i++) begin
        if ($urandom_range(0, 19) == 0) begin
          doc.push_back(8'h5C);
          doc.push_back(escs[$urandom_range(0, 7)]);
        end
        doc.push_back(nm[i]);
      end
      if ($urandom_range(0, 9) == 0) doc.push_back("x");
    end else begin
      repeat ($urandom_range(0, 14)) begin
        case ($urandom_range(0, 9))
          0: begin
            doc.push_back(8'h5C);
            doc.push_back(escs[$urandom_range(0, 7)]);
          end
          1: begin
            doc.push_back(8'h5C);
            doc.push_back("u");
            repeat (4) doc.push_back(hexs[$urandom_range(0, 21)]);
          end
          2: doc.push_back(8'($urandom_range(8'h80, 8'hFF)));
          default: begin
            nm = "a";
            nm[0] = 8'($urandom_range(8'h20, 8'h7E));
            if (nm[0] == 8'h22 || nm[0] == 8'h5C) nm[0] = "q";
            doc.push_back(nm[0]);
          end
        endcase
      end
    end
    doc.push_back(8'h22);
  endtask

  task automatic add_number();
    if ($urandom_range(0, 1)) doc.push_back("-");
    repeat ($urandom_range(1, 4)) doc.push_back(8'($urandom_range("0", "9")));
    if ($urandom_range(0, 2) == 0) begin
      doc.push_back(".");
      repeat ($urandom_range(1, 3)) doc.push_back(8'($urandom_range("0", "9")));
    end
    if ($urandom_range(0, 3) == 0) begin
      doc.push_back($urandom_range(0, 1) ? "e" : "E");
      doc.push_back($urandom_range(0, 1) ? "+" : "-");
      doc.push_back(8'($urandom_range("0", "9")));
    end
  endtask

  task automatic add_value(input int lvl, input bit container);
    int n, sel;
    sel = container ? $urandom_range(0, 1) : $urandom_range(0, 6);
    if (lvl >= 3 && sel < 2) sel = 2;
    case (sel)
      0: begin
        doc.push_back("{");
        add_ws();
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) begin doc.push_back(","); add_ws(); end
          add_string(1);
          add_ws();
          doc.push_back(":");
          add_ws();
          add_value(lvl + 1, 0);
          add_ws();
        end
        doc.push_back("}");
      end
      1: begin
        doc.push_back("[");
        add_ws();
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) begin doc.push_back(","); add_ws(); end
          add_value(lvl + 1, 0);
          add_ws();
        end
        doc.push_back("]");
      end
      2, 3: add_number();
      4: add_text($urandom_range(0, 2) == 0 ? "true" : ($urandom_range(0, 1) ? "false" : "null"));
      default: add_string(0);
    endcase
  endtask

  task automatic run_document();
    int n, pos;
    doc.delete();
    gappy = $urandom_range(0, 3) != 0;
    if ($urandom_range(0, 7) != 0) send_word(CMD_REINIT, 8'($urandom), 1'($urandom));
    if ($urandom_range(0, 11) == 0) begin
      // nesting around the stack limit
      n = $urandom_range(60, 68);
      repeat (n) doc.push_back("[");
      repeat (n) doc.push_back("]");
    end else begin
      add_ws();
      add_value(0, $urandom_range(0, 9) != 0);
      add_ws();
      if ($urandom_range(0, 4) == 0) doc.push_back($urandom_range(0, 1) ? 8'h20 : "x");
    end
    if ($urandom_range(0, 5) == 0) begin
      pos = $urandom_range(0, doc.size() - 1);
      doc[pos] = 8'($urandom);
    end
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(0, doc.size() - 1);
      while (doc.size() > n) void'(doc.pop_back());
    end
    foreach (doc[i]) begin
      send_word(CMD_FEED, doc[i], i == 0 || $urandom_range(0, 15) == 0);
      if ($urandom_range(0, 59) == 0) send_word(CMD_UNUSED, 8'($urandom), 1'($urandom));
    end
    send_word(CMD_FINISH, 8'($urandom), 1'($urandom));
    if ($urandom_range(0, 4) == 0) send_word(CMD_FINISH, 8'($urandom), 1'($urandom));
    if ($urandom_range(0, 4) == 0) send_word(CMD_FEED, 8'($urandom), 1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_word(CMD_FINISH, 8'h00, 0);
    send_word(CMD_UNUSED, 8'hFF, 1);
    feed_text("{\"id\":[-1,true]}", 1);
    send_word(CMD_FEED, 8'h20, 0);
    send_word(CMD_FEED, 8'h20, 1);
    send_word(CMD_FEED, "x", 0);
    send_word(CMD_FINISH, 8'hFF, 1);
    send_word(CMD_REINIT, 8'h00, 0);
    send_word(CMD_FEED, 8'hFF, 1);
    send_word(CMD_FEED, "{", 0);
    send_word(CMD_FINISH, 8'h00, 0);
    while (sent < 440) run_document();
    s_tvalid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("tb_json_structure_scanner_crc_unit passed");
    end else begin
      $display("tb_json_structure_scanner_crc_unit failed");
    end
    $finish;
  end

endmodule
